@@ rtl/sebpf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the shared edge bend pair finder: transfer structs and sequencer states.
// No dependencies.
package sebpf_pkg;

    localparam int FIELD_VERTEX_BITS = 16;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [FIELD_VERTEX_BITS-1:0] vertex_a;
        logic [FIELD_VERTEX_BITS-1:0] vertex_b;
        logic [FIELD_VERTEX_BITS-1:0] vertex_c;
    } tri_item_t;

    typedef struct packed {
        logic                         is_summary;
        logic [10:0]                  this_triangle;
        logic [9:0]                   earlier_triangle;
        logic [FIELD_VERTEX_BITS-1:0] opposite_earlier;
        logic [FIELD_VERTEX_BITS-1:0] shared_first;
        logic [FIELD_VERTEX_BITS-1:0] shared_second;
        logic [FIELD_VERTEX_BITS-1:0] opposite_later;
        logic [3:0]                   match_count;
        logic                         dropped;
        logic                         store_full;
        logic                         last;
    } res_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM
    } state_t;

endpackage

@@ rtl/shared_edge_bend_pair_finder_core.sv @@
`timescale 1ns / 1ps
// Top level of the shared edge bend pair finder: triangle store, scan sequencer, result register.
// Depends on sebpf_pkg.

// Each add item scans the triangle store oldest first, one stored triangle per cycle except
// while a bend quad waits on res_stall, through a single registered read port of the store
// and one shared nine-way corner compare unit; an add item with an empty store skips the scan.
// The summary also waits on res_stall. Every item ends with one summary transfer carrying
// last. tri_stall stays high from the accepted transfer until the summary has been loaded
// into the result register; the next item may enter while that summary waits.
module shared_edge_bend_pair_finder_core #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int VERTEX_BITS   = 16,
    parameter int MAX_MATCHES   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tri_valid,
    output logic                  tri_stall,
    input  sebpf_pkg::tri_item_t  tri_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output sebpf_pkg::res_item_t  res_item
);
    import sebpf_pkg::*;

    localparam int VB = (VERTEX_BITS < FIELD_VERTEX_BITS) ? VERTEX_BITS : FIELD_VERTEX_BITS;
    localparam int CW = $clog2(MAX_TRIANGLES + 1);
    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int MW = $clog2(MAX_MATCHES + 1);

    typedef logic [VB-1:0] vtx_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      self_reg, self_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [MW-1:0]      emitted_reg, emitted_next;
    logic               dropped_reg, dropped_next;
    logic               clear_reg, clear_next;
    vtx_t               nt_reg [3];
    vtx_t               nt_next [3];
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_next;

    logic [3*VB-1:0]    mem [MAX_TRIANGLES];
    logic [3*VB-1:0]    rd_data_reg;
    logic               rd_en;
    logic               wr_en;

    vtx_t               et [3];
    vtx_t               sh0, sh1, opp_e, opp_l;
    logic [3:0]         n_eq;
    logic               hit;
    logic               out_free;
    logic               full;
    logic               advance;

    function automatic vtx_t pick_opposite(input vtx_t t0, input vtx_t t1, input vtx_t t2,
                                           input vtx_t s1, input vtx_t s2);
        vtx_t r;
        r = '0;
        if (t2 != s1 && t2 != s2) r = t2;
        if (t1 != s1 && t1 != s2) r = t1;
        if (t0 != s1 && t0 != s2) r = t0;
        return r;
    endfunction

    assign et[0] = rd_data_reg[3*VB-1:2*VB];
    assign et[1] = rd_data_reg[2*VB-1:VB];
    assign et[2] = rd_data_reg[VB-1:0];

    always_comb
    begin
        n_eq = '0;
        sh0  = '0;
        sh1  = '0;
        for (int p = 0; p < 3; p++)
        begin
            for (int q = 0; q < 3; q++)
            begin
                if (et[p] == nt_reg[q])
                begin
                    if (n_eq == 4'd0) sh0 = et[p];
                    if (n_eq == 4'd1) sh1 = et[p];
                    n_eq = n_eq + 4'd1;
                end
            end
        end
        hit   = (n_eq == 4'd2);
        opp_e = pick_opposite(et[0], et[1], et[2], sh0, sh1);
        opp_l = pick_opposite(nt_reg[0], nt_reg[1], nt_reg[2], sh0, sh1);
    end

    assign out_free = !res_valid_reg || !res_stall;
    assign full     = (count_reg == CW'(MAX_TRIANGLES));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        self_next      = self_reg;
        j_next         = j_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = rd_valid_reg;
        emitted_next   = emitted_reg;
        dropped_next   = dropped_reg;
        clear_next     = clear_reg;
        nt_next        = nt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        advance        = 1'b0;
        tri_stall      = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                tri_stall = 1'b0;
                if (tri_valid)
                begin
                    emitted_next  = '0;
                    dropped_next  = 1'b0;
                    j_next        = '0;
                    rd_valid_next = 1'b0;
                    nt_next[0]    = tri_item.vertex_a[VB-1:0];
                    nt_next[1]    = tri_item.vertex_b[VB-1:0];
                    nt_next[2]    = tri_item.vertex_c[VB-1:0];
                    if (tri_item.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                        self_next  = '0;
                        clear_next = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        self_next  = count_reg;
                        clear_next = 1'b0;
                        state_next = (count_reg == '0) ? ST_SUM : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                advance = !(rd_valid_reg && hit && emitted_reg < MW'(MAX_MATCHES)) || out_free;
                if (advance)
                begin
                    if (rd_valid_reg && hit)
                    begin
                        if (emitted_reg < MW'(MAX_MATCHES))
                        begin
                            emitted_next              = emitted_reg + 1'b1;
                            res_valid_next            = 1'b1;
                            res_next                  = '0;
                            res_next.this_triangle    = 11'(self_reg);
                            res_next.earlier_triangle = 10'(rd_idx_reg);
                            res_next.opposite_earlier = 16'(opp_e);
                            res_next.shared_first     = 16'(sh0);
                            res_next.shared_second    = 16'(sh1);
                            res_next.opposite_later   = 16'(opp_l);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    if (j_reg < count_reg)
                    begin
                        rd_en         = 1'b1;
                        rd_idx_next   = j_reg[AW-1:0];
                        j_next        = j_reg + 1'b1;
                        rd_valid_next = 1'b1;
                    end
                    else
                    begin
                        rd_valid_next = 1'b0;
                        state_next    = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next               = '0;
                    res_next.is_summary    = 1'b1;
                    res_next.this_triangle = 11'(self_reg);
                    res_next.match_count   = 4'(emitted_reg);
                    res_next.dropped       = dropped_reg;
                    res_next.store_full    = !clear_reg && full;
                    res_next.last          = 1'b1;
                    if (!clear_reg && !full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            j_reg         <= '0;
            emitted_reg   <= '0;
            dropped_reg   <= 1'b0;
            clear_reg     <= 1'b0;
            self_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
            j_reg         <= j_next;
            emitted_reg   <= emitted_next;
            dropped_reg   <= dropped_next;
            clear_reg     <= clear_next;
            self_reg      <= self_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        nt_reg     <= nt_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= {nt_reg[0], nt_reg[1], nt_reg[2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[j_reg[AW-1:0]];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (tri_valid && !tri_stall) |=> tri_stall)
        else $error("item accepted while previous item still in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TRIANGLES))
        else $error("triangle count beyond store depth");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= MW'(MAX_MATCHES))
        else $error("more bend quads than the cap");

    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.last) |-> res_item.is_summary)
        else $error("last transfer is not the closing summary");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (j_reg < count_reg))
        else $error("store read beyond written entries");

endmodule
